// ----- hdl/c1d_pkg.sv -----
package c1d_pkg;

    // Default geometry
    localparam int TAPS_DEF    = 5;
    localparam int FILTERS_DEF = 3;
    localparam int MAX_ROW_DEF = 32;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int PSUM_W   = 40;
    localparam int PROD_W   = 2 * SAMPLE_W;
    // One guard bit: at most 16 taps of 2^30 each cannot carry past bit 40
    localparam int ACC_W    = PSUM_W + 1;
    localparam int NUM_OUT  = 3;
    localparam int IDX_W    = 5;

    // Command codes
    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PSUM_W-1:0]   psum_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // One accepted command item
    typedef struct packed {
        logic                       command;
        logic [1:0]                 filter_sel;
        logic [2:0]                 tap_sel;
        logic signed [SAMPLE_W-1:0] weight_value;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic signed [PSUM_W-1:0]   psum_in_a;
        logic signed [PSUM_W-1:0]   psum_in_b;
        logic signed [PSUM_W-1:0]   psum_in_c;
        logic                       row_last;
    } item_t;

    // Token control that travels down the cell chain
    typedef struct packed {
        logic                       valid;
        logic                       is_weight;
        logic                       is_result;
        logic [1:0]                 filter_sel;
        logic [2:0]                 tap_sel;
        logic signed [SAMPLE_W-1:0] weight;
        logic [IDX_W-1:0]           window_index;
        logic                       window_last;
    } ctrl_t;

endpackage

// ----- hdl/c1d_stream_if.sv -----
interface c1d_cmd_if;
    logic              valid;
    logic              ready;
    logic              command;
    logic [1:0]        filter_sel;
    logic [2:0]        tap_sel;
    c1d_pkg::sample_t  weight_value;
    c1d_pkg::sample_t  sample_value;
    c1d_pkg::psum_t    psum_in_a;
    c1d_pkg::psum_t    psum_in_b;
    c1d_pkg::psum_t    psum_in_c;
    logic              row_last;

    modport source (
        output valid, command, filter_sel, tap_sel, weight_value, sample_value,
               psum_in_a, psum_in_b, psum_in_c, row_last,
        input  ready
    );
    modport sink (
        input  valid, command, filter_sel, tap_sel, weight_value, sample_value,
               psum_in_a, psum_in_b, psum_in_c, row_last,
        output ready
    );
endinterface

interface c1d_res_if;
    logic              valid;
    logic              ready;
    c1d_pkg::psum_t    psum_out_a;
    c1d_pkg::psum_t    psum_out_b;
    c1d_pkg::psum_t    psum_out_c;
    logic [4:0]        window_index;
    logic              window_last;

    modport source (
        output valid, psum_out_a, psum_out_b, psum_out_c, window_index, window_last,
        input  ready
    );
    modport sink (
        input  valid, psum_out_a, psum_out_b, psum_out_c, window_index, window_last,
        output ready
    );
endinterface

// ----- hdl/c1d_front.sv -----
module c1d_front #(
    parameter int TAPS    = c1d_pkg::TAPS_DEF,
    parameter int MAX_ROW = c1d_pkg::MAX_ROW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  c1d_pkg::item_t   item,
    output c1d_pkg::ctrl_t   ctrl,
    output c1d_pkg::sample_t win [TAPS],
    output c1d_pkg::acc_t    acc [c1d_pkg::NUM_OUT]
);
    import c1d_pkg::*;

    localparam int HIST_D = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int SEEN_W = $clog2(TAPS + 1);
    localparam int WIN_W  = $clog2(MAX_ROW);

    sample_t            hist_reg [HIST_D];
    sample_t            hist_next [HIST_D];
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [WIN_W-1:0]   cnt_reg, cnt_next;
    logic [WIN_W+4:0]   cnt_wide;
    logic               is_sample;
    logic               full;

    assign is_sample = (item.command == CMD_SAMPLE);
    assign full      = (seen_reg == SEEN_W'(TAPS - 1));
    assign cnt_wide  = (WIN_W + 5)'(cnt_reg);

    // Window: stored history, newest sample at the top tap
    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            if (k < TAPS - 1)
                win[k] = hist_reg[k];
            else
                win[k] = item.sample_value;
        end
    end

    // Incoming partial sums seed the accumulators
    assign acc[0] = acc_t'(item.psum_in_a);
    assign acc[1] = acc_t'(item.psum_in_b);
    assign acc[2] = acc_t'(item.psum_in_c);

    // Token control for the head of the chain
    always_comb
    begin
        ctrl.valid        = take;
        ctrl.is_weight    = (item.command == CMD_WEIGHT);
        ctrl.is_result    = is_sample && full;
        ctrl.filter_sel   = item.filter_sel;
        ctrl.tap_sel      = item.tap_sel;
        ctrl.weight       = item.weight_value;
        ctrl.window_index = cnt_wide[IDX_W-1:0];
        ctrl.window_last  = item.row_last;
    end

    // Next history, fill count and window count
    always_comb
    begin
        for (int k = 0; k < HIST_D; k++)
        begin
            if (k + 1 < TAPS - 1)
                hist_next[k] = hist_reg[k + 1];
            else
                hist_next[k] = item.sample_value;
        end

        seen_next = seen_reg;
        if (!full)
            seen_next = seen_reg + SEEN_W'(1);

        cnt_next = cnt_reg;
        if (full && (cnt_reg < WIN_W'(MAX_ROW - 1)))
            cnt_next = cnt_reg + WIN_W'(1);

        // row end restarts the window
        if (item.row_last)
        begin
            seen_next = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_D; k++)
                hist_reg[k] <= '0;
            seen_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (take && is_sample)
        begin
            hist_reg <= hist_next;
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- hdl/c1d_cell.sv -----
module c1d_cell #(
    parameter int TAPS    = c1d_pkg::TAPS_DEF,
    parameter int FILTERS = c1d_pkg::FILTERS_DEF,
    parameter int K       = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  c1d_pkg::ctrl_t   up_ctrl,
    input  c1d_pkg::sample_t up_win [TAPS],
    input  c1d_pkg::acc_t    up_acc [c1d_pkg::NUM_OUT],
    input  c1d_pkg::prod_t   up_prod [c1d_pkg::NUM_OUT],
    output c1d_pkg::ctrl_t   dn_ctrl,
    output c1d_pkg::sample_t dn_win [TAPS],
    output c1d_pkg::acc_t    dn_acc [c1d_pkg::NUM_OUT],
    output c1d_pkg::prod_t   dn_prod [c1d_pkg::NUM_OUT]
);
    import c1d_pkg::*;

    sample_t w_reg [FILTERS];
    prod_t   prod_next [NUM_OUT];
    acc_t    acc_next [NUM_OUT];
    ctrl_t   ctrl_reg;
    sample_t win_reg [TAPS];
    acc_t    acc_reg [NUM_OUT];
    prod_t   prod_reg [NUM_OUT];
    logic    wr_hit;

    // Weight loads land when the token passes this tap, keeping item order
    assign wr_hit = adv && up_ctrl.valid && up_ctrl.is_weight && (int'(up_ctrl.tap_sel) == K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FILTERS; f++)
                w_reg[f] <= '0;
        end
        else if (wr_hit)
        begin
            for (int f = 0; f < FILTERS; f++)
            begin
                if (int'(up_ctrl.filter_sel) == f)
                    w_reg[f] <= up_ctrl.weight;
            end
        end
    end

    // Per lane: add the previous tap's product, form this tap's product
    for (genvar f = 0; f < NUM_OUT; f++)
    begin : g_lane
        if (f < FILTERS)
        begin : g_mul
            assign prod_next[f] = prod_t'(up_win[K]) * prod_t'(w_reg[f]);
        end
        else
        begin : g_zero
            assign prod_next[f] = '0;
        end
        assign acc_next[f] = up_acc[f] + acc_t'(up_prod[f]);
    end

    // Token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (adv)
            ctrl_reg <= up_ctrl;
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg  <= up_win;
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

    assign dn_ctrl = ctrl_reg;
    assign dn_win  = win_reg;
    assign dn_acc  = acc_reg;
    assign dn_prod = prod_reg;

endmodule

// ----- hdl/conv1d_row_three_filter_pe.sv -----
// Channel  Role    Carries
// -------  ------  ----------------------------------------------------------
// cmd      sink    weight loads and row samples, incoming partial sums
// res      source  saturated partial sums, window index, last-window flag
//
// One item is taken every cycle while the output register is empty or taken. A
// sample walks a chain of TAPS cells, one tap per cell, and its result passes
// through the cell registers into the output register. Reset clears weights,
// history and counters; no sweep needed. The whole chain advances only when the
// output register is empty or taken, so a stalled result holds cmd.ready low and freezes every cell.
module conv1d_row_three_filter_pe #(
    parameter int TAPS    = c1d_pkg::TAPS_DEF,
    parameter int FILTERS = c1d_pkg::FILTERS_DEF,
    parameter int MAX_ROW = c1d_pkg::MAX_ROW_DEF
) (
    input logic       clk,
    input logic       rst_n,
    c1d_cmd_if.sink   cmd,
    c1d_res_if.source res
);
    import c1d_pkg::*;

    logic    adv;
    logic    take;
    item_t   item;

    ctrl_t   ctrl_s [TAPS+1];
    sample_t win_s  [TAPS+1][TAPS];
    acc_t    acc_s  [TAPS+1][NUM_OUT];
    prod_t   prod_s [TAPS+1][NUM_OUT];

    acc_t    sum [NUM_OUT];
    psum_t   sat [NUM_OUT];

    logic    res_valid_reg;
    psum_t   psum_reg [NUM_OUT];
    logic [IDX_W-1:0] idx_reg;
    logic    last_reg;

    // Chain moves when the result slot is free
    assign adv       = !res_valid_reg || res.ready;
    assign cmd.ready = adv;
    assign take      = cmd.valid && adv;

    always_comb
    begin
        item.command      = cmd.command;
        item.filter_sel   = cmd.filter_sel;
        item.tap_sel      = cmd.tap_sel;
        item.weight_value = cmd.weight_value;
        item.sample_value = cmd.sample_value;
        item.psum_in_a    = cmd.psum_in_a;
        item.psum_in_b    = cmd.psum_in_b;
        item.psum_in_c    = cmd.psum_in_c;
        item.row_last     = cmd.row_last;
    end

    c1d_front #(
        .TAPS    (TAPS),
        .MAX_ROW (MAX_ROW)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .ctrl  (ctrl_s[0]),
        .win   (win_s[0]),
        .acc   (acc_s[0])
    );

    for (genvar f = 0; f < NUM_OUT; f++)
    begin : g_head
        assign prod_s[0][f] = '0;
    end

    // Cell chain, one tap per cell
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        c1d_cell #(
            .TAPS    (TAPS),
            .FILTERS (FILTERS),
            .K       (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .up_ctrl (ctrl_s[k]),
            .up_win  (win_s[k]),
            .up_acc  (acc_s[k]),
            .up_prod (prod_s[k]),
            .dn_ctrl (ctrl_s[k+1]),
            .dn_win  (win_s[k+1]),
            .dn_acc  (acc_s[k+1]),
            .dn_prod (prod_s[k+1])
        );
    end

    // Last tap's product, then clamp to 40 bits
    always_comb
    begin
        for (int f = 0; f < NUM_OUT; f++)
        begin
            sum[f] = acc_s[TAPS][f] + acc_t'(prod_s[TAPS][f]);
            if (sum[f][ACC_W-1] != sum[f][ACC_W-2])
            begin
                if (sum[f][ACC_W-1])
                    sat[f] = {1'b1, {(PSUM_W-1){1'b0}}};
                else
                    sat[f] = {1'b0, {(PSUM_W-1){1'b1}}};
            end
            else
            begin
                sat[f] = sum[f][PSUM_W-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= ctrl_s[TAPS].valid && ctrl_s[TAPS].is_result;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psum_reg <= sat;
            idx_reg  <= ctrl_s[TAPS].window_index;
            last_reg <= ctrl_s[TAPS].window_last;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.psum_out_a   = psum_reg[0];
    assign res.psum_out_b   = psum_reg[1];
    assign res.psum_out_c   = psum_reg[2];
    assign res.window_index = idx_reg;
    assign res.window_last  = last_reg;

endmodule
